### rtl/tcea_pkg.sv
// ----------------------------------------------------------------------------
// tcea_pkg: shared types and constants
// Widths, register codes and the front-to-back queue word of the
// three-channel energy accumulator.
// ----------------------------------------------------------------------------
package tcea_pkg;

	localparam int NumCh       = 3;
	localparam int RawW        = 16;
	localparam int MagW        = RawW - 1;       // clamped reading, sign dropped
	localparam int ProdW       = 2 * MagW;       // clamped shunt times clamped bus
	localparam int ChargeW     = 48;
	localparam int EnergyW     = 63;
	localparam int LimitW      = 16;
	localparam int CfgIdxW     = 1;
	localparam int CfgDataW    = 16;
	localparam int QueueDepthDef = 4;

	localparam logic [LimitW-1:0] UsbLimitRst  = 16'd2000;
	localparam logic [LimitW-1:0] PortLimitRst = 16'd800;

	// Channel order in every packed array: 0 USB, 1 port A, 2 port B
	localparam int ChUsb = 0;
	localparam int ChA   = 1;
	localparam int ChB   = 2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_USB_LIMIT  = 1'b0,
		CFG_PORT_LIMIT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [LimitW-1:0] usb;
		logic [LimitW-1:0] port;
	} limits_t;

	// One classified word handed from the front to the back
	typedef struct packed {
		logic [NumCh-1:0][MagW-1:0]  charge_inc;
		logic [NumCh-1:0][ProdW-1:0] energy_inc;
		logic [NumCh-1:0]            changed;
		logic                        accum;      // low on the baseline word
		logic                        clear;
	} qword_t;

endpackage

### rtl/tcea_if.sv
// ----------------------------------------------------------------------------
// tcea_meas_if / tcea_res_if: valid-ready channels
// Measurement word into the accumulator and totals word out of it.
// ----------------------------------------------------------------------------
interface tcea_meas_if;
	logic                               valid;
	logic                               ready;
	logic signed [tcea_pkg::RawW-1:0]   usb_shunt;
	logic signed [tcea_pkg::RawW-1:0]   usb_bus;
	logic signed [tcea_pkg::RawW-1:0]   a_shunt;
	logic signed [tcea_pkg::RawW-1:0]   a_bus;
	logic signed [tcea_pkg::RawW-1:0]   b_shunt;
	logic signed [tcea_pkg::RawW-1:0]   b_bus;
	logic                               clear_totals;

	modport source (
		output valid, usb_shunt, usb_bus, a_shunt, a_bus, b_shunt, b_bus, clear_totals,
		input  ready
	);
	modport sink (
		input  valid, usb_shunt, usb_bus, a_shunt, a_bus, b_shunt, b_bus, clear_totals,
		output ready
	);
endinterface

interface tcea_res_if;
	logic                              valid;
	logic                              ready;
	logic [tcea_pkg::ChargeW-1:0]      usb_charge;
	logic [tcea_pkg::ChargeW-1:0]      a_charge;
	logic [tcea_pkg::ChargeW-1:0]      b_charge;
	logic [tcea_pkg::EnergyW-1:0]      usb_energy;
	logic [tcea_pkg::EnergyW-1:0]      a_energy;
	logic [tcea_pkg::EnergyW-1:0]      b_energy;
	logic                              usb_changed;
	logic                              a_changed;
	logic                              b_changed;

	modport source (
		output valid, usb_charge, a_charge, b_charge, usb_energy, a_energy, b_energy,
		       usb_changed, a_changed, b_changed,
		input  ready
	);
	modport sink (
		input  valid, usb_charge, a_charge, b_charge, usb_energy, a_energy, b_energy,
		       usb_changed, a_changed, b_changed,
		output ready
	);
endinterface

### rtl/three_channel_energy_accumulator.sv
// ----------------------------------------------------------------------------
// three_channel_energy_accumulator: charge and energy meter for three channels
//
//   Channel  Dir  Carries
//   meas     in   raw shunt and bus readings of USB, port A, port B; clear flag
//   res      out  48-bit charge totals, 63-bit energy totals, change flags
//   cfg      in   write-only limits: 0 USB change limit, 1 port change limit
//
// One word per cycle sustained while res takes every word; a word taken at
// meas is written into the queue, then popped into the totals registers.
// The accumulate step (one 63-bit add and saturate per channel) sets the rate.
// Reset clears totals, baselines and the queue; limits return to 2000 and 800.
// The queue lets meas keep flowing while res is stalled, until it fills.
// ----------------------------------------------------------------------------
module three_channel_energy_accumulator #(
	parameter int QueueDepth = tcea_pkg::QueueDepthDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tcea_meas_if.sink                       meas,
	tcea_res_if.source                      res,
	input  logic                            cfg_we,
	input  tcea_pkg::cfg_idx_t              cfg_idx,
	input  logic [tcea_pkg::CfgDataW-1:0]   cfg_wdata
);
	import tcea_pkg::*;

	limits_t limits_q;
	qword_t  push_word;
	qword_t  pop_word;
	logic    push;
	logic    push_ready;
	logic    pop;
	logic    pop_valid;

	// Hold the change limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.usb  <= UsbLimitRst;
			limits_q.port <= PortLimitRst;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_USB_LIMIT:  limits_q.usb  <= LimitW'(cfg_wdata);
				CFG_PORT_LIMIT: limits_q.port <= LimitW'(cfg_wdata);
				default:        limits_q      <= limits_q;
			endcase
		end
	end

	tcea_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.meas    (meas),
		.limits  (limits_q),
		.q_ready (push_ready),
		.q_push  (push),
		.q_word  (push_word)
	);

	tcea_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_word   (pop_word),
		.pop_valid  (pop_valid)
	);

	tcea_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_word  (pop_word),
		.q_pop   (pop),
		.res     (res)
	);

endmodule

### rtl/tcea_front.sv
// ----------------------------------------------------------------------------
// tcea_front: measurement intake
// Accepts a measurement word, clamps the readings, forms the products and
// the change flags against the previous shunt baseline, and pushes one
// classified word into the queue.
// ----------------------------------------------------------------------------
module tcea_front (
	input  logic               clk,
	input  logic               arst_n,
	tcea_meas_if.sink          meas,
	input  tcea_pkg::limits_t  limits,
	input  logic               q_ready,
	output logic               q_push,
	output tcea_pkg::qword_t   q_word
);
	import tcea_pkg::*;

	logic [NumCh-1:0][RawW-1:0] shunt;
	logic [NumCh-1:0][RawW-1:0] bus;
	logic [NumCh-1:0][RawW-1:0] prev_shunt_q;
	logic                       baseline_q;

	logic signed [RawW:0]       diff;
	logic [RawW:0]              mag;
	logic [LimitW-1:0]          lim;
	logic [MagW-1:0]            cs;
	logic [MagW-1:0]            cb;

	assign shunt[ChUsb] = meas.usb_shunt;
	assign shunt[ChA]   = meas.a_shunt;
	assign shunt[ChB]   = meas.b_shunt;
	assign bus[ChUsb]   = meas.usb_bus;
	assign bus[ChA]     = meas.a_bus;
	assign bus[ChB]     = meas.b_bus;

	// Take a word whenever the queue has room
	assign meas.ready = q_ready;
	assign q_push     = meas.valid & q_ready;

	// Clamp, multiply and compare each channel on its own
	always_comb begin
		q_word          = '0;
		q_word.accum    = baseline_q;
		q_word.clear    = meas.clear_totals;
		diff            = '0;
		mag             = '0;
		lim             = '0;
		cs              = '0;
		cb              = '0;
		for (int ch = 0; ch < NumCh; ch++) begin
			cs   = shunt[ch][RawW-1] ? '0 : shunt[ch][MagW-1:0];
			cb   = bus[ch][RawW-1] ? '0 : bus[ch][MagW-1:0];
			q_word.charge_inc[ch] = cs;
			q_word.energy_inc[ch] = ProdW'(cs) * ProdW'(cb);
			diff = $signed({shunt[ch][RawW-1], shunt[ch]})
			     - $signed({prev_shunt_q[ch][RawW-1], prev_shunt_q[ch]});
			mag  = diff[RawW] ? (RawW+1)'(-diff) : diff;
			lim  = (ch == ChUsb) ? limits.usb : limits.port;
			q_word.changed[ch] = baseline_q & (mag > {1'b0, lim});
		end
	end

	// Record the baseline for the next word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_shunt_q <= '0;
			baseline_q   <= 1'b0;
		end else if (q_push) begin
			prev_shunt_q <= shunt;
			baseline_q   <= 1'b1;
		end
	end

endmodule

### rtl/tcea_queue.sv
// ----------------------------------------------------------------------------
// tcea_queue: front-to-back word queue
// Small first-in first-out buffer of classified words; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module tcea_queue #(
	parameter int QueueDepth = tcea_pkg::QueueDepthDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tcea_pkg::qword_t  push_word,
	output logic              push_ready,
	input  logic              pop,
	output tcea_pkg::qword_t  pop_word,
	output logic              pop_valid
);
	import tcea_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	qword_t            slot_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign push_ready = (count_q != CntW'(QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_word   = slot_q[rd_ptr_q];

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/tcea_back.sv
// ----------------------------------------------------------------------------
// tcea_back: saturating accumulators
// Pops classified words, clears and adds into the charge and energy totals
// with saturation, and presents the totals as the result word.
// ----------------------------------------------------------------------------
module tcea_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  tcea_pkg::qword_t  q_word,
	output logic              q_pop,
	tcea_res_if.source        res
);
	import tcea_pkg::*;

	logic [NumCh-1:0][ChargeW-1:0] charge_q;
	logic [NumCh-1:0][EnergyW-1:0] energy_q;
	logic [NumCh-1:0]              changed_q;
	logic                          res_valid_q;

	logic [NumCh-1:0][ChargeW-1:0] charge_nxt;
	logic [NumCh-1:0][EnergyW-1:0] energy_nxt;
	logic [ChargeW-1:0]            charge_base;
	logic [EnergyW-1:0]            energy_base;
	logic [ChargeW:0]              charge_sum;
	logic [EnergyW:0]              energy_sum;

	// Pop when the result slot is empty or being taken
	assign q_pop = q_valid & (~res_valid_q | res.ready);

	// Clear, then add with saturation at all ones; a baseline word is not added
	always_comb begin
		charge_nxt  = '0;
		energy_nxt  = '0;
		charge_base = '0;
		energy_base = '0;
		charge_sum  = '0;
		energy_sum  = '0;
		for (int ch = 0; ch < NumCh; ch++) begin
			charge_base = q_word.clear ? '0 : charge_q[ch];
			energy_base = q_word.clear ? '0 : energy_q[ch];
			charge_sum  = {1'b0, charge_base} + (ChargeW+1)'(q_word.charge_inc[ch]);
			energy_sum  = {1'b0, energy_base} + (EnergyW+1)'(q_word.energy_inc[ch]);
			if (!q_word.accum) begin
				charge_nxt[ch] = charge_base;
				energy_nxt[ch] = energy_base;
			end else begin
				charge_nxt[ch] = charge_sum[ChargeW] ? '1 : charge_sum[ChargeW-1:0];
				energy_nxt[ch] = energy_sum[EnergyW] ? '1 : energy_sum[EnergyW-1:0];
			end
		end
	end

	// Update totals and the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q    <= '0;
			energy_q    <= '0;
			changed_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				charge_q    <= charge_nxt;
				energy_q    <= energy_nxt;
				changed_q   <= q_word.changed;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.usb_charge  = charge_q[ChUsb];
	assign res.a_charge    = charge_q[ChA];
	assign res.b_charge    = charge_q[ChB];
	assign res.usb_energy  = energy_q[ChUsb];
	assign res.a_energy    = energy_q[ChA];
	assign res.b_energy    = energy_q[ChB];
	assign res.usb_changed = changed_q[ChUsb];
	assign res.a_changed   = changed_q[ChA];
	assign res.b_changed   = changed_q[ChB];

endmodule

### tb/three_channel_energy_accumulator_test.sv
// ----------------------------------------------------------------------------
// three_channel_energy_accumulator_test: self-checking bench for the meter
// Drives measurement words with random gaps, stalls the totals side at random
// and checks every totals word against a cycle-free model of the charge and
// energy totals and the per-channel change flags. The bench covers the
// baseline word after reset, the clamping of negative readings, totals
// clearing, change sizes at and around each limit, and limit extremes.
// ----------------------------------------------------------------------------
module three_channel_energy_accumulator_test;
	import tcea_pkg::*;

	typedef struct packed {
		logic [NumCh-1:0][RawW-1:0] shunt;
		logic [NumCh-1:0][RawW-1:0] bus;
		logic                       clear;
	} meas_word_t;

	typedef struct packed {
		logic [NumCh-1:0][ChargeW-1:0] charge;
		logic [NumCh-1:0][EnergyW-1:0] energy;
		logic [NumCh-1:0]              changed;
	} totals_word_t;

	// Running totals model plus the queue of totals words still owed by the block
	class energy_scoreboard;
		logic [LimitW-1:0] usb_limit;
		logic [LimitW-1:0] port_limit;
		int                last_shunt [NumCh];
		bit                have_baseline;
		logic [63:0]       charge_acc [NumCh];
		logic [63:0]       energy_acc [NumCh];
		totals_word_t      pending_totals [$];
		int                mismatches;

		function new();
			usb_limit     = UsbLimitRst;
			port_limit    = PortLimitRst;
			have_baseline = 1'b0;
			mismatches    = 0;
			for (int ch = 0; ch < NumCh; ch++) begin
				last_shunt[ch] = 0;
				charge_acc[ch] = '0;
				energy_acc[ch] = '0;
			end
		endfunction

		function void set_limit(cfg_idx_t idx, logic [CfgDataW-1:0] value);
			if (idx == CFG_USB_LIMIT)
				usb_limit = value;
			else
				port_limit = value;
		endfunction

		function logic [63:0] sat_add(logic [63:0] total, logic [63:0] inc, logic [63:0] cap);
			return (inc > cap - total) ? cap : total + inc;
		endfunction

		// Advance the totals for one accepted measurement word and queue the result
		function void note_measurement(meas_word_t m);
			totals_word_t t;
			int           s;
			int           b;
			int           d;
			int           mag;
			int           lim;
			logic [63:0]  cs;
			logic [63:0]  cb;
			t = '0;
			if (m.clear) begin
				for (int ch = 0; ch < NumCh; ch++) begin
					charge_acc[ch] = '0;
					energy_acc[ch] = '0;
				end
			end
			for (int ch = 0; ch < NumCh; ch++) begin
				s = $signed(m.shunt[ch]);
				b = $signed(m.bus[ch]);
				// the baseline word only records the shunt readings
				if (have_baseline) begin
					d   = s - last_shunt[ch];
					mag = (d < 0) ? -d : d;
					lim = (ch == ChUsb) ? int'(usb_limit) : int'(port_limit);
					cs  = (s > 0) ? 64'(s) : 64'd0;
					cb  = (b > 0) ? 64'(b) : 64'd0;
					t.changed[ch]  = (mag > lim);
					charge_acc[ch] = sat_add(charge_acc[ch], cs, (64'd1 << ChargeW) - 64'd1);
					energy_acc[ch] = sat_add(energy_acc[ch], cs * cb, (64'd1 << EnergyW) - 64'd1);
				end
				last_shunt[ch] = s;
				t.charge[ch]   = charge_acc[ch][ChargeW-1:0];
				t.energy[ch]   = energy_acc[ch][EnergyW-1:0];
			end
			have_baseline = 1'b1;
			pending_totals.push_back(t);
		endfunction

		function void log_mismatch(string what, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch %s: expected %0d got %0d", $time, what, want, got);
		endfunction

		// Compare one totals word with the oldest one owed
		function void check_totals(totals_word_t got);
			totals_word_t want;
			string        chan_name [NumCh];
			chan_name[ChUsb] = "usb";
			chan_name[ChA]   = "a";
			chan_name[ChB]   = "b";
			if (pending_totals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t mismatch: totals word with nothing owed", $time);
				return;
			end
			want = pending_totals.pop_front();
			for (int ch = 0; ch < NumCh; ch++) begin
				if (got.charge[ch] !== want.charge[ch])
					log_mismatch({chan_name[ch], "_charge"}, want.charge[ch], got.charge[ch]);
				if (got.energy[ch] !== want.energy[ch])
					log_mismatch({chan_name[ch], "_energy"}, want.energy[ch], got.energy[ch]);
				if (got.changed[ch] !== want.changed[ch])
					log_mismatch({chan_name[ch], "_changed"}, want.changed[ch], got.changed[ch]);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	cfg_idx_t            cfg_idx;
	logic [CfgDataW-1:0] cfg_wdata;

	tcea_meas_if meas_ch ();
	tcea_res_if  res_ch ();

	energy_scoreboard sb = new();

	bit           no_idle;
	int           usb_lim_now;
	int           port_lim_now;
	int           stim_prev [NumCh];
	meas_word_t   seen_meas;
	totals_word_t seen_totals;

	three_channel_energy_accumulator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.meas      (meas_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one, none in steady phases
	function automatic int idle_len();
		int r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic int extreme_value();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	// Favor shunt steps close to the channel limit, keep the rest broad
	function automatic int next_shunt(int prev, int lim);
		int r = $urandom_range(0, 99);
		int delta;
		int v;
		if (r < 35) begin
			delta = lim + int'($urandom_range(0, 2)) - 1;
			v = $urandom_range(0, 1) ? prev + delta : prev - delta;
			if (v > 32767 || v < -32768)
				v = 2 * prev - v;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			return v;
		end
		if (r < 60)
			return int'($urandom_range(0, 65535)) - 32768;
		if (r < 85)
			return int'($urandom_range(0, 32767));
		return extreme_value();
	endfunction

	function automatic int next_bus();
		int r = $urandom_range(0, 99);
		if (r < 50)
			return int'($urandom_range(0, 32767));
		if (r < 75)
			return int'($urandom_range(0, 65535)) - 32768;
		return extreme_value();
	endfunction

	function automatic meas_word_t make_word(int us, int as, int bs, int ub, int ab, int bb,
			bit clr);
		meas_word_t w;
		w.shunt[ChUsb] = 16'(us);
		w.shunt[ChA]   = 16'(as);
		w.shunt[ChB]   = 16'(bs);
		w.bus[ChUsb]   = 16'(ub);
		w.bus[ChA]     = 16'(ab);
		w.bus[ChB]     = 16'(bb);
		w.clear        = clr;
		return w;
	endfunction

	// Offer one measurement word after a random gap; return at the accepting edge
	task automatic send_measurement(meas_word_t w);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			meas_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		meas_ch.valid        <= 1'b1;
		meas_ch.usb_shunt    <= w.shunt[ChUsb];
		meas_ch.a_shunt      <= w.shunt[ChA];
		meas_ch.b_shunt      <= w.shunt[ChB];
		meas_ch.usb_bus      <= w.bus[ChUsb];
		meas_ch.a_bus        <= w.bus[ChA];
		meas_ch.b_bus        <= w.bus[ChB];
		meas_ch.clear_totals <= w.clear;
		@(posedge clk);
		while (!meas_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_random();
		meas_word_t w;
		int         v;
		for (int ch = 0; ch < NumCh; ch++) begin
			v = next_shunt(stim_prev[ch], (ch == ChUsb) ? usb_lim_now : port_lim_now);
			stim_prev[ch] = v;
			w.shunt[ch]   = 16'(v);
			w.bus[ch]     = 16'(next_bus());
		end
		w.clear = ($urandom_range(0, 99) < 3);
		send_measurement(w);
	endtask

	// Drop valid and wait until every owed totals word has come back
	task automatic settle();
		meas_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_totals.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write both limits back to back; only called while the block is idle
	task automatic write_limits(int usb_lim, int port_lim);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_USB_LIMIT;
		cfg_wdata <= CfgDataW'(usb_lim);
		@(posedge clk);
		cfg_idx   <= CFG_PORT_LIMIT;
		cfg_wdata <= CfgDataW'(port_lim);
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_limit(CFG_USB_LIMIT, CfgDataW'(usb_lim));
		sb.set_limit(CFG_PORT_LIMIT, CfgDataW'(port_lim));
		usb_lim_now  = usb_lim;
		port_lim_now = port_lim;
	endtask

	// Note every accepted measurement word
	always @(posedge clk) begin
		if (arst_n && meas_ch.valid && meas_ch.ready) begin
			seen_meas.shunt[ChUsb] = meas_ch.usb_shunt;
			seen_meas.shunt[ChA]   = meas_ch.a_shunt;
			seen_meas.shunt[ChB]   = meas_ch.b_shunt;
			seen_meas.bus[ChUsb]   = meas_ch.usb_bus;
			seen_meas.bus[ChA]     = meas_ch.a_bus;
			seen_meas.bus[ChB]     = meas_ch.b_bus;
			seen_meas.clear        = meas_ch.clear_totals;
			sb.note_measurement(seen_meas);
		end
	end

	// Check every accepted totals word
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen_totals.charge[ChUsb]  = res_ch.usb_charge;
			seen_totals.charge[ChA]    = res_ch.a_charge;
			seen_totals.charge[ChB]    = res_ch.b_charge;
			seen_totals.energy[ChUsb]  = res_ch.usb_energy;
			seen_totals.energy[ChA]    = res_ch.a_energy;
			seen_totals.energy[ChB]    = res_ch.b_energy;
			seen_totals.changed[ChUsb] = res_ch.usb_changed;
			seen_totals.changed[ChA]   = res_ch.a_changed;
			seen_totals.changed[ChB]   = res_ch.b_changed;
			sb.check_totals(seen_totals);
		end
	end

	// Stall the totals side at random
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = idle_len();
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		#6000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_idx              <= CFG_USB_LIMIT;
		cfg_wdata            <= '0;
		meas_ch.valid        <= 1'b0;
		meas_ch.usb_shunt    <= '0;
		meas_ch.a_shunt      <= '0;
		meas_ch.b_shunt      <= '0;
		meas_ch.usb_bus      <= '0;
		meas_ch.a_bus        <= '0;
		meas_ch.b_bus        <= '0;
		meas_ch.clear_totals <= 1'b0;
		no_idle      = 1'b0;
		usb_lim_now  = UsbLimitRst;
		port_lim_now = PortLimitRst;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// baseline word with clear, then full-scale swings and clamping
		send_measurement(make_word(-32768, 32767, 0, 32767, -32768, 0, 1'b1));
		send_measurement(make_word(32767, -32768, 1, 32767, 32767, -1, 1'b0));
		// steps exactly at the limit, then one past it (port B the other way round)
		send_measurement(make_word(30767, -31968, 802, 1, -1, 32767, 1'b0));
		send_measurement(make_word(28766, -31167, 2, -32768, 32767, 16384, 1'b0));
		send_measurement(make_word(100, 200, 300, 1000, 2000, 3000, 1'b1));
		send_measurement(make_word(100, 200, 300, 32767, 32767, 32767, 1'b0));
		settle();

		// zero limits: no step stays quiet, a step of one fires
		write_limits(0, 0);
		send_measurement(make_word(100, 200, 300, 5, 6, 7, 1'b0));
		send_measurement(make_word(101, 199, 300, 32767, 0, 1, 1'b0));
		settle();

		// top limits: even the widest step stays quiet
		write_limits(65535, 65535);
		send_measurement(make_word(-32768, 32767, -32768, 8, 9, 10, 1'b0));
		send_measurement(make_word(32767, -32768, 32767, 32767, 32767, 32767, 1'b0));
		settle();

		write_limits(65534, 65534);
		send_measurement(make_word(-32768, 32767, -32768, -32768, 1, 32767, 1'b0));
		send_measurement(make_word(-32768, 32767, -32768, 32767, -1, 0, 1'b0));
		stim_prev[ChUsb] = -32768;
		stim_prev[ChA]   = 32767;
		stim_prev[ChB]   = -32768;

		// random phases, each under its own limits
		for (int phase = 0; phase < 7; phase++) begin
			settle();
			case (phase)
				0: write_limits(UsbLimitRst, PortLimitRst);
				1: write_limits(0, 65535);
				2: write_limits(65535, 0);
				default: begin
					if (phase % 2)
						write_limits($urandom_range(0, 65535), $urandom_range(0, 2000));
					else
						write_limits($urandom_range(0, 3000), $urandom_range(0, 2000));
				end
			endcase
			no_idle = (phase == 2 || phase == 5);
			repeat (100) send_random();
		end
		settle();

		if (sb.mismatches == 0 && sb.pending_totals.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### three_channel_energy_accumulator.f
rtl/tcea_pkg.sv
rtl/tcea_if.sv
rtl/tcea_front.sv
rtl/tcea_queue.sv
rtl/tcea_back.sv
rtl/three_channel_energy_accumulator.sv
tb/three_channel_energy_accumulator_test.sv
